FILE: rtl/pir_pkg.sv
`timescale 1ns / 1ps

package pir_pkg;

	localparam int DEPTH  = 64;
	localparam int DATA_W = 32;
	localparam int POS_W  = 7;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [1:0] OP_PUSH   = 2'd0;
	localparam logic [1:0] OP_POP    = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_INSERT = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_BADPOS = 2'd3;

	typedef struct packed {
		logic              go;
		logic              up;
		logic [ADDR_W-1:0] first;
		logic [CNT_W-1:0]  len;
	} walk_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] taken;
	} walk_stat_t;

endpackage

FILE: rtl/pir_ram.sv
`timescale 1ns / 1ps

module pir_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/pir_walk.sv
`timescale 1ns / 1ps

module pir_walk (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pir_pkg::walk_req_t             req,
	input  logic [pir_pkg::DATA_W-1:0]     rdata,
	output logic                           re,
	output logic [pir_pkg::ADDR_W-1:0]     raddr,
	output logic                           we,
	output logic [pir_pkg::ADDR_W-1:0]     waddr,
	output logic [pir_pkg::DATA_W-1:0]     wdata,
	output pir_pkg::walk_stat_t            stat
);

	logic                          active_q;
	logic                          pend_q;
	logic                          first_q;
	logic [pir_pkg::CNT_W-1:0]     left_q;
	logic                          up_q;
	logic [pir_pkg::ADDR_W-1:0]    rd_q;
	logic [pir_pkg::ADDR_W-1:0]    last_q;
	logic [pir_pkg::DATA_W-1:0]    taken_q;
	logic                          take_now;
	logic                          more;

	assign more     = (left_q != '0);
	assign take_now = up_q && first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pend_q   <= 1'b0;
			first_q  <= 1'b0;
			left_q   <= '0;
		end else if (req.go) begin
			active_q <= 1'b1;
			pend_q   <= 1'b0;
			first_q  <= 1'b1;
			left_q   <= req.len;
		end else if (active_q) begin
			if (pend_q) begin
				first_q <= 1'b0;
			end
			if (more) begin
				left_q <= left_q - pir_pkg::CNT_W'(1);
				pend_q <= 1'b1;
			end else begin
				pend_q <= 1'b0;
			end
			if (!more && !pend_q) begin
				active_q <= 1'b0;
			end
		end
	end

	// address stepper: ascending closes a gap, descending opens one
	always_ff @(posedge clk) begin
		if (req.go) begin
			rd_q <= req.first;
			up_q <= req.up;
		end else if (active_q && more) begin
			rd_q   <= up_q ? rd_q + pir_pkg::ADDR_W'(1) : rd_q - pir_pkg::ADDR_W'(1);
			last_q <= rd_q;
		end
		if (active_q && pend_q && take_now) begin
			taken_q <= rdata;
		end
	end

	assign re         = active_q && more;
	assign raddr      = rd_q;
	assign we         = active_q && pend_q && !take_now;
	assign waddr      = up_q ? last_q - pir_pkg::ADDR_W'(1) : last_q + pir_pkg::ADDR_W'(1);
	assign wdata      = rdata;
	assign stat.done  = active_q && !more && !pend_q;
	assign stat.taken = taken_q;

	a_pend_active: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> active_q)
		else $error("read data pending while walk is idle");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done && !req.go |=> !active_q)
		else $error("walk did not stop after done");

	a_no_go_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.go |-> !active_q)
		else $error("walk started while still active");

endmodule

FILE: rtl/positional_insert_remove_array.sv
`timescale 1ns / 1ps

// Ordered list of up to pir_pkg::DEPTH signed 32-bit words with push, pop, remove at a
// 1-based position and insert at a 1-based position. A command is taken when start is
// high and busy is low; busy then stays high until its single result word has been shown
// for one cycle with done high. The receiver cannot stall, so it must take the word in that
// cycle. Pop, remove and insert run through one RAM read port and one write port, moving
// one entry per cycle: remove reads the entry at the position and rewrites every later
// entry one place down, while insert rewrites every entry from the position to the end
// one place up. The RAM needs no clearing after reset.
module positional_insert_remove_array (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     op,
	input  logic [pir_pkg::POS_W-1:0]      position,
	input  logic signed [31:0]             value,
	output logic                           done,
	output logic [1:0]                     status,
	output logic signed [31:0]             taken_value,
	output logic [pir_pkg::POS_W-1:0]      count_after
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_WALK  = 3'd2;
	localparam logic [2:0] S_FILL  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]                    state_q;
	logic [pir_pkg::CNT_W-1:0]     count_q;
	logic [1:0]                    op_q;
	logic [pir_pkg::POS_W-1:0]     pos_q;
	logic [pir_pkg::DATA_W-1:0]    val_q;
	logic [1:0]                    status_q;
	logic [pir_pkg::DATA_W-1:0]    taken_q;

	logic [pir_pkg::CMP_W-1:0]     cnt_x;
	logic [pir_pkg::CMP_W-1:0]     pos_x;
	logic [pir_pkg::CMP_W-1:0]     len_x;
	logic [pir_pkg::CMP_W-1:0]     pos_m1;
	logic [pir_pkg::CNT_W-1:0]     cnt_m1;
	logic                          empty;
	logic                          full;
	logic                          pos_bad;
	logic                          accept;

	pir_pkg::walk_req_t            wreq;
	pir_pkg::walk_stat_t           wstat;

	logic                          top_we;
	logic [pir_pkg::ADDR_W-1:0]    top_waddr;
	logic                          walk_we;
	logic [pir_pkg::ADDR_W-1:0]    walk_waddr;
	logic [pir_pkg::DATA_W-1:0]    walk_wdata;
	logic                          ram_re;
	logic [pir_pkg::ADDR_W-1:0]    ram_raddr;
	logic [pir_pkg::DATA_W-1:0]    ram_rdata;
	logic                          ram_we;
	logic [pir_pkg::ADDR_W-1:0]    ram_waddr;
	logic [pir_pkg::DATA_W-1:0]    ram_wdata;

	assign accept  = start && (state_q == S_IDLE);
	assign cnt_x   = pir_pkg::CMP_W'(count_q);
	assign pos_x   = pir_pkg::CMP_W'(pos_q);
	assign len_x   = cnt_x - pos_x + pir_pkg::CMP_W'(1);
	assign pos_m1  = pos_x - pir_pkg::CMP_W'(1);
	assign cnt_m1  = count_q - pir_pkg::CNT_W'(1);
	assign empty   = (count_q == '0);
	assign full    = (cnt_x == pir_pkg::CMP_W'(pir_pkg::DEPTH));
	assign pos_bad = (pos_x == '0) || (pos_x > cnt_x);

	// walk request: pop is a remove at the last position
	always_comb begin
		wreq.go    = 1'b0;
		wreq.up    = 1'b1;
		wreq.first = cnt_m1[pir_pkg::ADDR_W-1:0];
		wreq.len   = pir_pkg::CNT_W'(1);
		if (state_q == S_CHECK) begin
			case (op_q)
				pir_pkg::OP_POP: begin
					wreq.go = !empty;
				end
				pir_pkg::OP_REMOVE: begin
					wreq.go    = !empty && !pos_bad;
					wreq.first = pos_m1[pir_pkg::ADDR_W-1:0];
					wreq.len   = len_x[pir_pkg::CNT_W-1:0];
				end
				pir_pkg::OP_INSERT: begin
					wreq.go  = !full && !pos_bad;
					wreq.up  = 1'b0;
					wreq.len = len_x[pir_pkg::CNT_W-1:0];
				end
				default: begin
					wreq.go = 1'b0;
				end
			endcase
		end
	end

	assign top_we    = ((state_q == S_CHECK) && (op_q == pir_pkg::OP_PUSH) && !full) ||
	                   (state_q == S_FILL);
	assign top_waddr = (state_q == S_FILL) ? pos_m1[pir_pkg::ADDR_W-1:0]
	                                       : count_q[pir_pkg::ADDR_W-1:0];
	assign ram_we    = top_we || walk_we;
	assign ram_waddr = top_we ? top_waddr : walk_waddr;
	assign ram_wdata = top_we ? val_q : walk_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (wreq.go) begin
						state_q <= S_WALK;
					end else begin
						state_q <= S_DONE;
						if (top_we) begin
							count_q <= count_q + pir_pkg::CNT_W'(1);
						end
					end
				end
				S_WALK: begin
					if (wstat.done) begin
						if (op_q == pir_pkg::OP_INSERT) begin
							state_q <= S_FILL;
						end else begin
							state_q <= S_DONE;
							count_q <= cnt_m1;
						end
					end
				end
				S_FILL: begin
					state_q <= S_DONE;
					count_q <= count_q + pir_pkg::CNT_W'(1);
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op;
			pos_q <= position;
			val_q <= value;
		end
		if (state_q == S_CHECK) begin
			taken_q <= '0;
			case (op_q)
				pir_pkg::OP_PUSH:   status_q <= full ? pir_pkg::ST_FULL : pir_pkg::ST_OK;
				pir_pkg::OP_POP:    status_q <= empty ? pir_pkg::ST_EMPTY : pir_pkg::ST_OK;
				pir_pkg::OP_REMOVE: status_q <= empty   ? pir_pkg::ST_EMPTY :
				                                pos_bad ? pir_pkg::ST_BADPOS : pir_pkg::ST_OK;
				default:            status_q <= full    ? pir_pkg::ST_FULL :
				                                pos_bad ? pir_pkg::ST_BADPOS : pir_pkg::ST_OK;
			endcase
		end else if ((state_q == S_WALK) && wstat.done && (op_q != pir_pkg::OP_INSERT)) begin
			taken_q <= wstat.taken;
		end
	end

	pir_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (wreq),
		.rdata  (ram_rdata),
		.re     (ram_re),
		.raddr  (ram_raddr),
		.we     (walk_we),
		.waddr  (walk_waddr),
		.wdata  (walk_wdata),
		.stat   (wstat)
	);

	pir_ram #(
		.WIDTH (pir_pkg::DATA_W),
		.DEPTH (pir_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign busy        = (state_q != S_IDLE);
	assign done        = (state_q == S_DONE);
	assign status      = status_q;
	assign taken_value = taken_q;
	assign count_after = cnt_x[pir_pkg::POS_W-1:0];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_x <= pir_pkg::CMP_W'(pir_pkg::DEPTH))
		else $error("entry count above capacity");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted word did not raise busy");

	a_wport_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(top_we && walk_we))
		else $error("two writers on the ram port");

	a_fail_taken: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != pir_pkg::ST_OK) |-> (taken_value == '0))
		else $error("failed command returned a word");

endmodule
